// ===== rtl/cfe_pkg.sv =====
// Package for the checksummed register frame encoder.
// Holds request codes, sync constants and the command record passed front to back.
// No dependencies.
`timescale 1ns / 1ps

package cfe_pkg;

  typedef enum logic [1:0] {
    REQ_READ     = 2'd0,
    REQ_WR_START = 2'd1,
    REQ_WR_DATA  = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'hCA;

  localparam int QUEUE_DEPTH_DEF = 2;

  // Up to four frame bytes, first byte in the low bits.
  typedef struct packed {
    logic [31:0] bytes;
    logic [1:0]  last_idx; // index of the final byte in this record
    logic        ends;     // final byte closes the frame
  } cmd_t;

endpackage

// ===== rtl/cfe_front.sv =====
// Front end: accepts requests, tracks the open write frame and checksums,
// and turns each request that yields bytes into a byte record for the queue. Uses cfe_pkg.
`timescale 1ns / 1ps

module cfe_front
  import cfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        q_full,
  output logic        push,
  output cmd_t        push_cmd
);

  logic [7:0] sum_a_r, sum_a_nxt;
  logic [7:0] sum_b_r, sum_b_nxt;
  logic [4:0] words_left_r, words_left_nxt;
  logic       write_open_r, write_open_nxt;

  req_t        kind;
  logic [9:0]  addr;
  logic [4:0]  count;
  logic [15:0] data;
  logic [7:0]  hdr;
  logic [7:0]  a1, b1, a2, b2;
  logic [4:0]  wl_dec;
  logic        acc;

  assign kind  = req_t'(in_tuser);
  assign addr  = in_tdata[9:0];
  assign count = in_tdata[14:10];
  assign data  = in_tdata[30:15];
  assign hdr   = {(kind == REQ_WR_START), count, addr[9:8]};

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign wl_dec    = words_left_r - 5'd1;

  always_comb begin
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    words_left_nxt = words_left_r;
    write_open_nxt = write_open_r;
    push           = 1'b0;
    push_cmd       = '0;
    a1 = 8'd0;
    b1 = 8'd0;
    a2 = 8'd0;
    b2 = 8'd0;
    case (kind)
      REQ_READ: begin
        if (acc && !write_open_r) begin
          push = 1'b1;
          push_cmd.bytes    = {addr[7:0], hdr, SYNC_SECOND, SYNC_FIRST};
          push_cmd.last_idx = 2'd3;
          push_cmd.ends     = 1'b1;
        end
      end
      REQ_WR_START: begin
        a1 = hdr;
        b1 = hdr;
        a2 = a1 + addr[7:0];
        b2 = b1 + a2;
        if (acc && !write_open_r && count != 5'd0) begin
          push = 1'b1;
          push_cmd.bytes    = {addr[7:0], hdr, SYNC_SECOND, SYNC_FIRST};
          push_cmd.last_idx = 2'd3;
          push_cmd.ends     = 1'b0;
          sum_a_nxt      = a2;
          sum_b_nxt      = b2;
          words_left_nxt = count;
          write_open_nxt = 1'b1;
        end
      end
      REQ_WR_DATA: begin
        a1 = sum_a_r + data[15:8];
        b1 = sum_b_r + a1;
        a2 = a1 + data[7:0];
        b2 = b1 + a2;
        if (acc && write_open_r) begin
          push = 1'b1;
          sum_a_nxt      = a2;
          sum_b_nxt      = b2;
          words_left_nxt = wl_dec;
          if (wl_dec == 5'd0) begin
            // last word: checksum bytes follow the data bytes
            push_cmd.bytes    = {b2, a2, data[7:0], data[15:8]};
            push_cmd.last_idx = 2'd3;
            push_cmd.ends     = 1'b1;
            write_open_nxt    = 1'b0;
          end else begin
            push_cmd.bytes    = {16'd0, data[7:0], data[15:8]};
            push_cmd.last_idx = 2'd1;
            push_cmd.ends     = 1'b0;
          end
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_a_r      <= 8'd0;
      sum_b_r      <= 8'd0;
      words_left_r <= 5'd0;
      write_open_r <= 1'b0;
    end else begin
      sum_a_r      <= sum_a_nxt;
      sum_b_r      <= sum_b_nxt;
      words_left_r <= words_left_nxt;
      write_open_r <= write_open_nxt;
    end
  end

endmodule

// ===== rtl/cfe_queue.sv =====
// Short command queue between front and back end.
// Register-based FIFO of cmd_t records. Uses cfe_pkg.
`timescale 1ns / 1ps

module cfe_queue
  import cfe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/cfe_back.sv =====
// Back end: walks the head record of the queue one byte per cycle, while out_tready allows, into
// the registered output stream. Uses cfe_pkg.
`timescale 1ns / 1ps

module cfe_back
  import cfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       empty,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       advance;
  logic       at_end;

  assign advance = !out_valid_r || out_tready;
  assign at_end  = (idx_r == head.last_idx);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    idx_nxt       = idx_r;
    pop           = 1'b0;
    if (advance) begin
      out_valid_nxt = !empty;
      if (!empty) begin
        out_byte_nxt = head.bytes[{idx_r, 3'b000} +: 8];
        out_last_nxt = head.ends && at_end;
        pop          = at_end;
        idx_nxt      = at_end ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/checksummed_register_frame_encoder_core.sv =====
// Checksummed register frame encoder. Each accepted request becomes up to four
// bytes of a serial-link frame (sync, header, address, data, checksum sums); the
// output stream moves one byte per cycle while out_tready allows, from a single
// output register. A read, a write start or the final data word of a frame yields
// four bytes, any other data word two; requests that yield nothing push no record.
// The front end accepts a new request every cycle while the command queue
// (QUEUE_DEPTH records) has room, independent of output backpressure.
// Depends on cfe_pkg, cfe_front, cfe_queue and cfe_back.
`timescale 1ns / 1ps

module checksummed_register_frame_encoder_core
  import cfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // target_addr[9:0], word_count[14:10], data_word[30:15], 0
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast   // frame_end
);

  logic push, q_full, pop, q_empty;
  cmd_t push_cmd, head;

  cfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  cfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  cfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (q_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/cfe_checker.sv =====
// Port-level checks for the frame encoder, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module cfe_stream_props (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic after_last_r;

  // set when the next output transaction must open a new frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_last_r <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      after_last_r <= out_tlast;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_frame_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && after_last_r) |-> (out_tdata == 8'hAA))
    else $error("frame does not open with sync byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output changed");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_tvalid) |-> $past(out_tready))
    else $error("output valid dropped without transaction");

endmodule

bind checksummed_register_frame_encoder_core cfe_stream_props u_cfe_stream_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
